FILE: design/prfp_pkg.sv
`default_nettype none
package prfp_pkg;

	localparam int unsigned HEADER_BYTES = 24;
	localparam int unsigned ADDR_FIRST   = 10;
	localparam int unsigned ADDR_LAST    = 15;

	localparam logic [7:0] MASK_RESET = 8'h02;

	// Register index taken from paddr[2]; bits [1:0] are the byte offset.
	localparam logic REG_ADDR_MASK = 1'b0;

	localparam logic KIND_SSID    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_TAG    = 5'b00010,
		PH_LEN    = 5'b00100,
		PH_BODY   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  ssid_byte;
		logic [47:0] source_address;
		logic        address_randomized;
		logic [5:0]  ssid_length;
		logic [7:0]  strength;
		logic [7:0]  channel;
	} res_t;

endpackage
`default_nettype wire

FILE: design/probe_request_frame_parser.sv
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   one frame byte with length and receive metadata
// m_*       out        m_tvalid / m_tready   one SSID byte or a frame summary (m_tuser)
// apb       in         psel, penable, pready random_address_mask at byte address 0
//
// One item is accepted per cycle while s_tready is high. An item sits in the input register,
// where the parse state is updated, and its result lands in the output register.
// The input register empties whenever the output register is empty, is being
// read, or the item produces no result; otherwise s_tready drops.
// Reset clears the parse state, both valid flags and sets the mask to 2.
`default_nettype none
module probe_request_frame_parser
	import prfp_pkg::*;
#(
	parameter int LENGTH_BITS    = 12,
	parameter int MAX_SSID_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] frame_byte, then frame_length, signal_strength, radio_channel, zero fill
	input  wire logic [((24 + LENGTH_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] ssid_byte, [55:8] source_address, [56] address_randomized,
	// [62:57] ssid_length, [70:63] strength_out, [78:71] channel_out, [79] zero
	output logic      [79:0] m_tdata,
	// [0] result_kind
	output logic      [0:0]  m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int LEN_LO = 8;
	localparam int STR_LO = LEN_LO + LENGTH_BITS;
	localparam int CH_LO  = STR_LO + 8;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic [LENGTH_BITS-1:0] len_s1;
	logic [7:0]             strength_s1;
	logic [7:0]             channel_s1;

	logic       out_valid_q;
	res_t       out_q;
	logic [7:0] mask;
	logic       emit;
	res_t       res;
	logic       advance;

	prfp_apb_regs u_regs (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.random_address_mask (mask)
	);

	prfp_core #(
		.LENGTH_BITS    (LENGTH_BITS),
		.MAX_SSID_BYTES (MAX_SSID_BYTES)
	) u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (advance),
		.frame_byte          (byte_s1),
		.frame_length        (len_s1),
		.signal_strength     (strength_s1),
		.radio_channel       (channel_s1),
		.random_address_mask (mask),
		.emit                (emit),
		.res                 (res)
	);

	assign advance  = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1     <= s_tdata[7:0];
			len_s1      <= s_tdata[LEN_LO +: LENGTH_BITS];
			strength_s1 <= s_tdata[STR_LO +: 8];
			channel_s1  <= s_tdata[CH_LO +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {1'b0, out_q.channel, out_q.strength, out_q.ssid_length,
	                   out_q.address_randomized, out_q.source_address, out_q.ssid_byte};

endmodule
`default_nettype wire

FILE: design/prfp_apb_regs.sv
`default_nettype none
module prfp_apb_regs
	import prfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [7:0]  random_address_mask
);

	logic [7:0] mask_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ADDR_MASK) begin
			mask_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ADDR_MASK) begin
			prdata = {24'd0, mask_q};
		end
	end

	assign random_address_mask = mask_q;

endmodule
`default_nettype wire

FILE: design/prfp_core.sv
`default_nettype none
module prfp_core
	import prfp_pkg::*;
#(
	parameter int LENGTH_BITS    = 12,
	parameter int MAX_SSID_BYTES = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             frame_byte,
	input  wire logic [LENGTH_BITS-1:0] frame_length,
	input  wire logic [7:0]             signal_strength,
	input  wire logic [7:0]             radio_channel,
	input  wire logic [7:0]             random_address_mask,
	output logic                        emit,
	output res_t                        res
);

	localparam int CNT_W = $clog2(MAX_SSID_BYTES + 1);
	localparam int LW    = LENGTH_BITS + 2;

	logic [LENGTH_BITS-1:0] pos_q;
	logic [47:0]            addr_q;
	phase_t                 phase_q;
	logic [7:0]             left_q;
	logic                   is_ssid_q;
	logic [CNT_W-1:0]       count_q;

	logic             last;
	logic             long_enough;
	logic             ssid_emit;
	logic [CNT_W-1:0] count_inc;

	assign last        = (LW'(pos_q) + LW'(1)) >= LW'(frame_length);
	assign long_enough = LW'(frame_length) >= LW'(HEADER_BYTES);
	assign ssid_emit   = !last && phase_q == PH_BODY && is_ssid_q
	                     && count_q < CNT_W'(MAX_SSID_BYTES);
	assign count_inc   = count_q + CNT_W'(1);
	assign emit        = (last && long_enough) || ssid_emit;

	always_comb begin
		res.kind               = last ? KIND_SUMMARY : KIND_SSID;
		res.ssid_byte          = last ? 8'd0 : frame_byte;
		res.source_address     = addr_q;
		res.address_randomized = |(addr_q[47:40] & random_address_mask);
		res.ssid_length        = last ? 6'(count_q) : 6'(count_inc);
		res.strength           = signal_strength;
		res.channel            = radio_channel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			addr_q    <= '0;
			phase_q   <= PH_HEADER;
			left_q    <= '0;
			is_ssid_q <= 1'b0;
			count_q   <= '0;
		end else if (step) begin
			if (last) begin
				// Frame ends here, whatever the phase: back to the header state.
				pos_q     <= '0;
				addr_q    <= '0;
				phase_q   <= PH_HEADER;
				left_q    <= '0;
				is_ssid_q <= 1'b0;
				count_q   <= '0;
			end else begin
				pos_q <= pos_q + LENGTH_BITS'(1);
				case (phase_q)
					PH_HEADER: begin
						if (LW'(pos_q) >= LW'(ADDR_FIRST) && LW'(pos_q) <= LW'(ADDR_LAST)) begin
							addr_q <= {addr_q[39:0], frame_byte};
						end
						if (LW'(pos_q) + LW'(1) >= LW'(HEADER_BYTES)) begin
							phase_q <= PH_TAG;
						end
					end
					PH_TAG: begin
						is_ssid_q <= (frame_byte == 8'd0);
						phase_q   <= PH_LEN;
					end
					PH_LEN: begin
						// The element overruns the frame if its body ends past the last byte.
						if (LW'(pos_q) + LW'(1) + LW'(frame_byte) > LW'(frame_length)) begin
							phase_q <= PH_DONE;
						end else if (frame_byte == 8'd0) begin
							phase_q <= is_ssid_q ? PH_DONE : PH_TAG;
						end else begin
							left_q  <= frame_byte;
							phase_q <= PH_BODY;
						end
					end
					PH_BODY: begin
						if (ssid_emit) begin
							count_q <= count_inc;
						end
						left_q <= left_q - 8'd1;
						if (left_q == 8'd1) begin
							phase_q <= is_ssid_q ? PH_DONE : PH_TAG;
						end
					end
					default: begin
						phase_q <= PH_DONE;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/prfp_checker.sv
`default_nettype none
module prfp_checker #(
	parameter int LENGTH_BITS    = 12,
	parameter int MAX_SSID_BYTES = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [((24 + LENGTH_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	localparam logic COUNT_WRAPS = MAX_SSID_BYTES >= 64;

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("result changed while stalled");

	// With the output register empty, the input register can always drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
	else $error("input stalled with an empty output register");

	// A summary carries no SSID byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0)
	else $error("summary with a nonzero ssid byte");

	// An SSID byte is counted in its own length, unless MAX_SSID_BYTES >= 64 lets the 6-bit length wrap.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> COUNT_WRAPS || m_tdata[62:57] != 6'd0)
	else $error("ssid byte with a zero length");

endmodule

bind probe_request_frame_parser prfp_checker #(
	.LENGTH_BITS    (LENGTH_BITS),
	.MAX_SSID_BYTES (MAX_SSID_BYTES)
) u_prfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
